/* rtl/olkd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package olkd_pkg;

  localparam int DEPTH    = 32;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int KEY_W    = 32;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT   = 3'd0,
    KIND_POP_HEAD = 3'd1,
    KIND_POP_TAIL = 3'd2,
    KIND_DEL_KEY  = 3'd3,
    KIND_DUMP     = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 3'd0,
    ST_NONE  = 3'd1,
    ST_FULL  = 3'd2,
    ST_ELEM  = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  // Operation broadcast to every cell of the chain at once.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP_HEAD,
    OP_POP_TAIL,
    OP_DEL_KEY,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                op;
    logic signed [KEY_W-1:0] key;
  } cell_cmd_t;

endpackage
`default_nettype wire

/* rtl/olkd_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
interface olkd_in_if;
  logic                             valid;
  logic                             ready;
  logic [olkd_pkg::KIND_W-1:0]      kind;
  logic signed [olkd_pkg::KEY_W-1:0] key;

  modport source (output valid, output kind, output key, input ready);
  modport sink   (input valid, input kind, input key, output ready);
endinterface

interface olkd_out_if;
  logic                              valid;
  logic                              ready;
  logic [olkd_pkg::STATUS_W-1:0]     status;
  logic signed [olkd_pkg::KEY_W-1:0] item_key;
  logic                              last;

  modport source (output valid, output status, output item_key, output last, input ready);
  modport sink   (input valid, input status, input item_key, input last, output ready);
endinterface
`default_nettype wire

/* rtl/ordered_list_with_key_delete.sv */
`timescale 1ns / 1ps
`default_nettype none
// Results: each accepted command's result is registered in the output register; a dump
//   first enters S_DUMP, then loads its first element. Throughput: one command per cycle
//   for insert, remove, empty-list dump and unknown kinds while the output side keeps up.
// Dump: after the accepting cycle, each element is emitted from the head as the chain
//   rotates, pausing on output stalls; no input is taken until the last element is out.
// Reset (rst, synchronous): empty list and clear output valid; keys and output payload are not reset.
module ordered_list_with_key_delete (
  input  wire logic clk,
  input  wire logic rst,
  olkd_in_if.sink   in_ch,
  olkd_out_if.source out_ch
);

  localparam int DEPTH = olkd_pkg::DEPTH;
  localparam int CNT_W = olkd_pkg::CNT_W;
  localparam int KEY_W = olkd_pkg::KEY_W;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  state_t state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] dump_left;

  // Output register.
  logic                              out_valid;
  olkd_pkg::status_t                 out_status;
  logic signed [KEY_W-1:0]           out_key;
  logic                              out_last;

  // Result to load this cycle.
  logic                    res_load;
  olkd_pkg::status_t       res_status;
  logic signed [KEY_W-1:0] res_key;
  logic                    res_last;
  logic                    dump_start;

  olkd_pkg::cell_cmd_t     cmd;
  logic signed [KEY_W-1:0] cell_key [DEPTH];
  logic [DEPTH-1:0]        cell_valid;
  logic [DEPTH:0]          hit_chain;

  logic slot_free;
  logic in_fire;
  logic full;
  logic empty;
  logic found;

  assign slot_free = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE) && slot_free;
  assign in_fire = in_ch.valid && in_ch.ready;

  // The list is always packed toward the head, so the end cells tell full and empty.
  assign full  = cell_valid[DEPTH-1];
  assign empty = !cell_valid[0];
  assign found = hit_chain[DEPTH];

  assign hit_chain[0] = 1'b0;

  // Cell chain: cell 0 is the head, each cell talks only to its neighbors,
  // plus the broadcast command and the head key for rotation.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [KEY_W-1:0] l_key;
    logic                    l_valid;
    logic signed [KEY_W-1:0] r_key;
    logic                    r_valid;

    if (i == 0) begin : g_head
      assign l_key   = cmd.key;
      assign l_valid = 1'b1;
    end else begin : g_mid
      assign l_key   = cell_key[i-1];
      assign l_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_key   = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_key   = cell_key[i+1];
      assign r_valid = cell_valid[i+1];
    end

    olkd_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .left_key    (l_key),
      .left_valid  (l_valid),
      .right_key   (r_key),
      .right_valid (r_valid),
      .head_key    (cell_key[0]),
      .hit_in      (hit_chain[i]),
      .hit_out     (hit_chain[i+1]),
      .key         (cell_key[i]),
      .valid       (cell_valid[i])
    );
  end

  // Decode the accepted command, or step the dump.
  always_comb begin
    cmd.op     = olkd_pkg::OP_HOLD;
    cmd.key    = in_ch.key;
    res_load   = 1'b0;
    res_status = olkd_pkg::ST_DONE;
    res_key    = '0;
    res_last   = 1'b1;
    dump_start = 1'b0;
    count_next = count;

    if (state == S_DUMP) begin
      if (slot_free) begin
        // Emit the head, then rotate so the next element comes up front.
        cmd.op     = olkd_pkg::OP_ROTATE;
        res_load   = 1'b1;
        res_status = olkd_pkg::ST_ELEM;
        res_key    = cell_key[0];
        res_last   = (dump_left == CNT_W'(1));
      end
    end else if (in_fire) begin
      res_load = 1'b1;
      unique case (olkd_pkg::kind_t'(in_ch.kind))
        olkd_pkg::KIND_INSERT: begin
          if (full) begin
            res_status = olkd_pkg::ST_FULL;
          end else begin
            cmd.op     = olkd_pkg::OP_INSERT;
            count_next = count + CNT_W'(1);
          end
        end
        olkd_pkg::KIND_POP_HEAD: begin
          if (empty) begin
            res_status = olkd_pkg::ST_NONE;
          end else begin
            cmd.op     = olkd_pkg::OP_POP_HEAD;
            count_next = count - CNT_W'(1);
          end
        end
        olkd_pkg::KIND_POP_TAIL: begin
          if (empty) begin
            res_status = olkd_pkg::ST_NONE;
          end else begin
            cmd.op     = olkd_pkg::OP_POP_TAIL;
            count_next = count - CNT_W'(1);
          end
        end
        olkd_pkg::KIND_DEL_KEY: begin
          // With no match the hit chain stays low and no cell moves.
          cmd.op = olkd_pkg::OP_DEL_KEY;
          if (found) begin
            count_next = count - CNT_W'(1);
          end else begin
            res_status = olkd_pkg::ST_NONE;
          end
        end
        olkd_pkg::KIND_DUMP: begin
          if (empty) begin
            res_status = olkd_pkg::ST_EMPTY;
          end else begin
            res_load   = 1'b0;
            dump_start = 1'b1;
          end
        end
        default: begin
          res_status = olkd_pkg::ST_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dump_left <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;

      unique case (state)
        S_IDLE: begin
          if (dump_start) begin
            state     <= S_DUMP;
            dump_left <= count;
          end
        end
        S_DUMP: begin
          if (slot_free) begin
            dump_left <= dump_left - CNT_W'(1);
            if (dump_left == CNT_W'(1)) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload of the output register; held while the sink stalls.
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status <= res_status;
      out_key    <= res_key;
      out_last   <= res_last;
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.status   = out_status;
  assign out_ch.item_key = out_key;
  assign out_ch.last     = out_last;

  // The count register and the cell valid bits must agree.
  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count))
    else $error("count disagrees with valid cells");

  // Valid cells are packed toward the head.
  a_cells_packed: assert property (@(posedge clk) disable iff (rst)
    (cell_valid & ~(cell_valid >> 1)) == (cell_valid ^ (cell_valid >> 1)))
    else $error("valid cells not contiguous from the head");

  // An accepted insert into a non-full list grows it by one.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (in_ch.kind == olkd_pkg::KIND_INSERT) && !full)
      |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not grow the list");

  // The final dump element ends the dump and is flagged last.
  a_dump_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP && slot_free && dump_left == CNT_W'(1))
      |=> (state == S_IDLE && out_valid && out_last))
    else $error("dump did not end on its last element");

endmodule
`default_nettype wire

/* rtl/olkd_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module olkd_cell (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire olkd_pkg::cell_cmd_t               cmd,
  input  wire logic signed [olkd_pkg::KEY_W-1:0] left_key,
  input  wire logic                              left_valid,
  input  wire logic signed [olkd_pkg::KEY_W-1:0] right_key,
  input  wire logic                              right_valid,
  input  wire logic signed [olkd_pkg::KEY_W-1:0] head_key,
  input  wire logic                              hit_in,
  output logic                                   hit_out,
  output logic signed [olkd_pkg::KEY_W-1:0]      key,
  output logic                                   valid
);

  // First match nearest the head: every cell at or past it closes the gap.
  assign hit_out = hit_in | (valid && (key == cmd.key));

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      olkd_pkg::OP_INSERT:   key <= left_key;
      olkd_pkg::OP_POP_HEAD: key <= right_key;
      olkd_pkg::OP_DEL_KEY: begin
        if (hit_out) key <= right_key;
      end
      // Rotate among valid cells: the last one takes the head.
      olkd_pkg::OP_ROTATE:   key <= right_valid ? right_key : head_key;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (cmd.op)
        olkd_pkg::OP_INSERT:   valid <= left_valid;
        olkd_pkg::OP_POP_HEAD: valid <= right_valid;
        olkd_pkg::OP_POP_TAIL: valid <= valid & right_valid;
        olkd_pkg::OP_DEL_KEY: begin
          if (hit_out) valid <= right_valid;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Hold in_ch.valid with its payload until the transfer. Check each output transfer against
// the oldest expected result.
module tb_top;

  localparam int STALL_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int LONG_HOLD   = 100;   // long output back-pressure, in cycles
  localparam int HOLD_AFTER  = 60;    // results to collect before the long hold
  localparam int TAIL_CYCLES = 10;    // settle time after the last result

  typedef logic [olkd_pkg::KIND_W-1:0]       kind_bits_t;
  typedef logic signed [olkd_pkg::KEY_W-1:0] key_t;

  typedef struct {
    kind_bits_t kind;
    key_t       key;
    bit         drain;  // hold this command until every result is in
  } command_t;

  typedef struct {
    olkd_pkg::status_t status;
    key_t              item_key;
    logic              last;
  } list_result_t;

  logic clk;
  logic rst;

  olkd_in_if  in_ch ();
  olkd_out_if out_ch ();

  ordered_list_with_key_delete dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  command_t     cmd_q[$];        // commands not yet offered
  list_result_t owed_q[$];       // results the block still owes, oldest first
  key_t         shadow_list[$];  // our copy of the list, head first
  int           owed_total;      // results predicted so far (driver side)
  int           got_total;       // results collected so far (monitor side)
  int           mismatches;
  int           stall_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one accepted command to the shadow list and queue the results it owes.
  function automatic void apply_command(kind_bits_t kind, key_t key);
    list_result_t r;
    int           hit;
    r.status   = olkd_pkg::ST_NONE;
    r.item_key = '0;
    r.last     = 1'b1;
    hit        = -1;
    case (kind)
      olkd_pkg::KIND_INSERT: begin
        if (shadow_list.size() >= olkd_pkg::DEPTH) begin
          r.status = olkd_pkg::ST_FULL;
        end else begin
          shadow_list.push_front(key);
          r.status = olkd_pkg::ST_DONE;
        end
      end
      olkd_pkg::KIND_POP_HEAD: begin
        if (shadow_list.size() != 0) begin
          void'(shadow_list.pop_front());
          r.status = olkd_pkg::ST_DONE;
        end
      end
      olkd_pkg::KIND_POP_TAIL: begin
        if (shadow_list.size() != 0) begin
          void'(shadow_list.pop_back());
          r.status = olkd_pkg::ST_DONE;
        end
      end
      olkd_pkg::KIND_DEL_KEY: begin
        // Remove only the match nearest the head.
        for (int i = 0; i < shadow_list.size(); i++) begin
          if (hit < 0 && shadow_list[i] == key) hit = i;
        end
        if (hit >= 0) begin
          shadow_list.delete(hit);
          r.status = olkd_pkg::ST_DONE;
        end
      end
      olkd_pkg::KIND_DUMP: begin
        if (shadow_list.size() == 0) begin
          r.status = olkd_pkg::ST_EMPTY;
        end else begin
          // One element per result, head to tail, flag the tail.
          foreach (shadow_list[i]) begin
            r.status   = olkd_pkg::ST_ELEM;
            r.item_key = shadow_list[i];
            r.last     = (i == shadow_list.size() - 1);
            owed_q.push_back(r);
          end
          owed_total += shadow_list.size();
          return;
        end
      end
      default: ;  // unknown kinds leave the list alone and report nothing removed
    endcase
    owed_q.push_back(r);
    owed_total++;
  endfunction

  // Favor a small pool of keys so deletes hit and duplicates occur; keep some fully random.
  function automatic key_t pick_key();
    key_t pool [8];
    pool = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, -1, 1, 2, 3, 32'sh5A5A_A5A5};
    if ($urandom_range(0, 9) < 6) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic int pick_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic push_cmd(kind_bits_t kind, key_t key, bit drain);
    command_t c;
    c.kind  = kind;
    c.key   = key;
    c.drain = drain;
    cmd_q.push_back(c);
  endtask

  // Queue a run of random commands with the given weights; drain before its first one.
  task automatic push_phase(int n, int w_ins, int w_head, int w_tail, int w_del, int w_dump,
                            int w_bad);
    int         roll;
    kind_bits_t kind;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, w_ins + w_head + w_tail + w_del + w_dump + w_bad - 1);
      if (roll < w_ins) kind = olkd_pkg::KIND_INSERT;
      else if (roll < w_ins + w_head) kind = olkd_pkg::KIND_POP_HEAD;
      else if (roll < w_ins + w_head + w_tail) kind = olkd_pkg::KIND_POP_TAIL;
      else if (roll < w_ins + w_head + w_tail + w_del) kind = olkd_pkg::KIND_DEL_KEY;
      else if (roll < w_ins + w_head + w_tail + w_del + w_dump) kind = olkd_pkg::KIND_DUMP;
      else kind = kind_bits_t'($urandom_range(5, 7));
      push_cmd(kind, pick_key(), i == 0);
    end
  endtask

  // Driver: advance to the next command once the current one transfers.
  bit tx_calm;
  int tx_wait;
  always @(posedge clk) begin
    command_t c;
    if (rst) begin
      in_ch.valid <= 1'b0;
      tx_wait = 0;
      tx_calm = 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        apply_command(in_ch.kind, in_ch.key);
        // Switch between idle-free stretches and random gaps now and then.
        if ($urandom_range(0, 11) == 0) tx_calm = ~tx_calm;
        tx_wait = pick_gap(tx_calm);
      end
      if (tx_wait > 0) begin
        tx_wait--;
        in_ch.valid <= 1'b0;
      end else if (cmd_q.size() != 0 && !(cmd_q[0].drain && got_total != owed_total)) begin
        c = cmd_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.kind  <= c.kind;
        in_ch.key   <= c.key;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each output transfer with the oldest owed result, then pace ready.
  bit rx_calm;
  bit rx_held;
  int rx_wait;
  int rx_count;
  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      rx_wait  = 0;
      rx_calm  = 1'b0;
      rx_held  = 1'b0;
      rx_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (owed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result: status=%0d item_key=%0d last=%0b", $realtime,
                     out_ch.status, out_ch.item_key, out_ch.last);
        end else begin
          want = owed_q.pop_front();
          rx_count++;
          if (out_ch.status !== want.status || out_ch.item_key !== want.item_key ||
              out_ch.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("[%0t] result %0d: expected status=%0d item_key=%0d last=%0b,",
                     $realtime, rx_count, want.status, want.item_key, want.last);
              $display(" got status=%0d item_key=%0d last=%0b",
                       out_ch.status, out_ch.item_key, out_ch.last);
            end
          end
        end
        if ($urandom_range(0, 11) == 0) rx_calm = ~rx_calm;
        rx_wait = pick_gap(rx_calm);
      end
      // Hold off once for a long stretch while input is still offered, so the block backs up.
      if (!rx_held && rx_count >= HOLD_AFTER && in_ch.valid) begin
        rx_held = 1'b1;
        rx_wait = LONG_HOLD;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      got_total <= rx_count;
    end
  end

  // Watchdog: end the run if neither side transfers for too long.
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.kind   = '0;
    in_ch.key    = '0;
    out_ch.ready = 1'b0;
    owed_total   = 0;
    got_total    = 0;
    mismatches   = 0;
    rst          = 1'b1;

    // Directed: every command on an empty list, unknown kinds, key extremes,
    // duplicate keys for nearest-head delete, an absent key, and dumps between.
    push_cmd(olkd_pkg::KIND_DUMP, 0, 1'b0);
    push_cmd(olkd_pkg::KIND_POP_HEAD, 0, 1'b0);
    push_cmd(olkd_pkg::KIND_POP_TAIL, 0, 1'b0);
    push_cmd(olkd_pkg::KIND_DEL_KEY, 5, 1'b0);
    push_cmd(kind_bits_t'(5), 32'sh7FFF_FFFF, 1'b0);
    push_cmd(kind_bits_t'(6), -1, 1'b0);
    push_cmd(kind_bits_t'(7), 0, 1'b0);
    push_cmd(olkd_pkg::KIND_INSERT, 32'sh8000_0000, 1'b0);
    push_cmd(olkd_pkg::KIND_INSERT, 32'sh7FFF_FFFF, 1'b0);
    push_cmd(olkd_pkg::KIND_INSERT, 0, 1'b0);
    push_cmd(olkd_pkg::KIND_INSERT, -1, 1'b0);
    push_cmd(olkd_pkg::KIND_INSERT, 32'sh7FFF_FFFF, 1'b0);
    push_cmd(olkd_pkg::KIND_DUMP, 0, 1'b0);
    push_cmd(olkd_pkg::KIND_DEL_KEY, 32'sh7FFF_FFFF, 1'b0);
    push_cmd(olkd_pkg::KIND_DEL_KEY, 12345, 1'b0);
    push_cmd(olkd_pkg::KIND_DUMP, 0, 1'b0);
    push_cmd(olkd_pkg::KIND_POP_HEAD, 0, 1'b0);
    push_cmd(olkd_pkg::KIND_POP_TAIL, 0, 1'b0);
    push_cmd(olkd_pkg::KIND_INSERT, 1, 1'b0);
    push_cmd(olkd_pkg::KIND_DUMP, 0, 1'b0);

    // Random: fill past capacity, then a mixed run, then mostly removals to empty it again.
    push_phase(40, 90, 1, 1, 3, 4, 1);
    push_phase(38, 35, 15, 15, 20, 10, 5);
    push_phase(32, 15, 25, 25, 20, 10, 5);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Drain: every command offered and transferred, every owed result collected.
    @(negedge clk);
    while (cmd_q.size() != 0 || in_ch.valid || owed_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    mismatches += owed_q.size();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* ordered_list_with_key_delete.f */
rtl/olkd_pkg.sv
rtl/olkd_ifs.sv
rtl/olkd_cell.sv
rtl/ordered_list_with_key_delete.sv
dv/tb_top.sv
